/* hw/rtl/fixed_block_free_list_allocator_assert.svh */
// Assertion macros for the fixed block free list allocator
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// clocked check, off during reset
`define FBFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked implication, off during reset
`define FBFL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/fbfl_pkg.sv */
// Package for the fixed block free list allocator: types and constants
package fbfl_pkg;

  localparam int DEFAULT_NUM_BLOCKS = 4096;
  localparam int RESET_BLOCK_LIMIT  = 4096;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_REUSED   = 3'd1,
    ST_OOM      = 3'd2,
    ST_FREED    = 3'd3,
    ST_RANGE    = 3'd4,
    ST_ALREADY  = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_status_t;

endpackage

/* hw/rtl/fbfl_ram.sv */
// Simple dual-port RAM with registered read
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/fbfl_ctrl.sv */
// Controller state machine for the fixed block free list allocator
module fbfl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_stall,
  input  fbfl_pkg::dp_status_t st,
  output fbfl_pkg::dp_cmd_t    cmd
);

  fbfl_pkg::fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbfl_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    in_stall    = 1'b1;
    unique case (state)
      fbfl_pkg::FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = fbfl_pkg::FSM_EXEC;
        end
      end
      fbfl_pkg::FSM_EXEC: begin
        // wait until the output register can take the result
        if (!st.out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = fbfl_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = fbfl_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/fbfl_dp.sv */
// Datapath for the fixed block free list allocator: counters, head, link RAM, result register
module fbfl_dp #(
  parameter int NUM_BLOCKS = fbfl_pkg::DEFAULT_NUM_BLOCKS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fbfl_pkg::dp_cmd_t                 cmd,
  output fbfl_pkg::dp_status_t              st,
  input  logic                              action,
  input  logic [$clog2(NUM_BLOCKS)-1:0]     target_block,
  input  logic                              block_limit_we,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]   block_limit,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [2:0]                        status,
  output logic [$clog2(NUM_BLOCKS)-1:0]     granted_block,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]   blocks_in_use,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]   blocks_appended
);

  localparam int ID_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int ENT_W = CNT_W + 1;
  localparam int LIMIT_RESET = (fbfl_pkg::RESET_BLOCK_LIMIT > NUM_BLOCKS) ?
                               NUM_BLOCKS : fbfl_pkg::RESET_BLOCK_LIMIT;
  localparam logic [CNT_W-1:0] EMPTY = CNT_W'(NUM_BLOCKS);

  // list and counters
  logic [CNT_W-1:0] head, head_next;
  logic [CNT_W-1:0] appended, appended_next;
  logic [CNT_W-1:0] in_use, in_use_next;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] eff_limit;

  // captured request
  logic             act;
  logic [ID_W-1:0]  tgt;

  // RAM entry: {used mark, next link}
  logic             ram_we;
  logic [ID_W-1:0]  ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ID_W-1:0]  ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  fbfl_pkg::status_t res_status;
  logic [ID_W-1:0]   res_granted;

  assign ram_raddr = (action == fbfl_pkg::ACT_FREE) ? target_block : head[ID_W-1:0];
  assign eff_limit = (limit > EMPTY) ? EMPTY : limit;
  assign st.out_valid = out_valid;

  fbfl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_BLOCKS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.capture),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    head_next     = head;
    appended_next = appended;
    in_use_next   = in_use;
    ram_we        = 1'b0;
    ram_waddr     = tgt;
    ram_wdata     = {1'b0, head};
    res_status    = fbfl_pkg::ST_OOM;
    res_granted   = '0;
    if (act == fbfl_pkg::ACT_ALLOC) begin
      if (head < EMPTY) begin
        head_next   = ram_rdata[CNT_W-1:0];
        in_use_next = in_use + 1'b1;
        ram_we      = 1'b1;
        ram_waddr   = head[ID_W-1:0];
        ram_wdata   = {1'b1, ram_rdata[CNT_W-1:0]};
        res_granted = head[ID_W-1:0];
        res_status  = fbfl_pkg::ST_REUSED;
      end else if (appended < eff_limit) begin
        appended_next = appended + 1'b1;
        in_use_next   = in_use + 1'b1;
        ram_we        = 1'b1;
        ram_waddr     = appended[ID_W-1:0];
        ram_wdata     = {1'b1, EMPTY};
        res_granted   = appended[ID_W-1:0];
        res_status    = fbfl_pkg::ST_APPENDED;
      end
    end else begin
      if (CNT_W'(tgt) >= appended) begin
        res_status = fbfl_pkg::ST_RANGE;
      end else if (!ram_rdata[CNT_W]) begin
        res_status = fbfl_pkg::ST_ALREADY;
      end else begin
        head_next  = CNT_W'(tgt);
        ram_we     = 1'b1;
        if (in_use != '0) begin
          in_use_next = in_use - 1'b1;
        end
        res_status = fbfl_pkg::ST_FREED;
      end
    end
    if (!cmd.commit) begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= EMPTY;
      appended  <= '0;
      in_use    <= '0;
      limit     <= CNT_W'(LIMIT_RESET);
      out_valid <= 1'b0;
    end else begin
      if (block_limit_we) begin
        limit <= block_limit;
      end
      if (cmd.commit) begin
        head      <= head_next;
        appended  <= appended_next;
        in_use    <= in_use_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act <= action;
      tgt <= target_block;
    end
    if (cmd.commit) begin
      status          <= res_status;
      granted_block   <= res_granted;
      blocks_in_use   <= in_use_next;
      blocks_appended <= appended_next;
    end
  end

endmodule

/* hw/rtl/fixed_block_free_list_allocator.sv */
// Top level of the fixed block free list allocator
// Each request is handled in order: the head link or used mark is read from the
// block RAM, then the list, counters and RAM are updated and the result register loaded,
// once the output register is free. No new request is taken until the last one commits.
// Synchronous reset empties the list and clears both counters; no RAM clearing pass.
`include "fixed_block_free_list_allocator_assert.svh"
module fixed_block_free_list_allocator #(
  parameter int NUM_BLOCKS = fbfl_pkg::DEFAULT_NUM_BLOCKS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              block_limit_we,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]   block_limit,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [$clog2(NUM_BLOCKS)-1:0]     target_block,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic [$clog2(NUM_BLOCKS)-1:0]     granted_block,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]   blocks_in_use,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]   blocks_appended
);

  fbfl_pkg::dp_cmd_t    cmd;
  fbfl_pkg::dp_status_t st;

  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_stall(out_stall),
    .st       (st),
    .cmd      (cmd)
  );

  fbfl_dp #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .action         (action),
    .target_block   (target_block),
    .block_limit_we (block_limit_we),
    .block_limit    (block_limit),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .granted_block  (granted_block),
    .blocks_in_use  (blocks_in_use),
    .blocks_appended(blocks_appended)
  );

  `FBFL_ASSERT(a_cmd_excl, !(cmd.capture && cmd.commit), "capture and commit together")
  `FBFL_ASSERT_IMPL(a_no_overwrite, cmd.commit, !out_valid || !out_stall, "result overwritten")
  `FBFL_ASSERT_IMPL(a_one_at_a_time, in_valid && !in_stall, ##1 in_stall, "second transfer taken early")
  `FBFL_ASSERT_IMPL(a_counts, out_valid, blocks_in_use <= blocks_appended, "in use above appended")
  `FBFL_ASSERT_IMPL(a_grant_zero, out_valid && status != fbfl_pkg::ST_APPENDED && status != fbfl_pkg::ST_REUSED, granted_block == '0, "grant set without allocation")

endmodule
